// File: rtl/core/sipu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipu_pkg
// Shared constants for the segment intersection point unit.
// ----------------------------------------------------------------------------
package sipu_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned PointW       = 32;

endpackage

// File: rtl/core/sipu_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipu_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module sipu_div_cell #(
  parameter int unsigned DW = 35,
  parameter int unsigned QW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] acc_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] acc_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_d, rem_q, den_q;
  logic [QW-1:0] acc_d, acc_q;

  // acc holds the dividend bits still to use in its top, quotient bits in its bottom
  always_comb begin
    trial = {rem_i, acc_i[QW-1]};
    diff  = trial - {1'b0, den_i};
    fits  = ~diff[DW];
    rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
    acc_d = {acc_i[QW-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      acc_q <= acc_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign acc_o = acc_q;

endmodule

// File: rtl/core/segment_intersection_point_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_unit
// Proper-crossing test of two segments by cross-product signs, with the
// crossing point in signed fixed point, truncated toward zero.
// ----------------------------------------------------------------------------
// four front stages, one division cell per quotient bit, one output register.
// throughput: one request per cycle; the divider is a chain of cells, one per
// quotient bit, and the whole pipeline holds only while the output waits.
// reset clears all valid bits; data registers are not reset.
module segment_intersection_point_unit
  import sipu_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] seg1_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg1_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg1_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg1_end_y_i,
  input  logic signed [COORD_BITS-1:0] seg2_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg2_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg2_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg2_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic signed [PointW-1:0]     point_x_o,
  output logic signed [PointW-1:0]     point_y_o
);

  localparam int unsigned DFW = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DFW;
  localparam int unsigned CW  = PW + 1;
  localparam int unsigned NW  = CW + DFW;
  localparam int unsigned QW  = DFW + FRAC_BITS;
  localparam int unsigned RW  = COORD_BITS + FRAC_BITS + 2;
  localparam int unsigned SBW = 3 + 2 * COORD_BITS;

  logic en;
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // stage 1: differences
  logic                         v1_q;
  logic signed [DFW-1:0]        d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [DFW-1:0]        ex_q, ey_q, fx_q, fy_q, hx_q, hy_q;
  logic signed [COORD_BITS-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1x_q <= DFW'(seg1_end_x_i) - DFW'(seg1_start_x_i);
      d1y_q <= DFW'(seg1_end_y_i) - DFW'(seg1_start_y_i);
      d2x_q <= DFW'(seg2_end_x_i) - DFW'(seg2_start_x_i);
      d2y_q <= DFW'(seg2_end_y_i) - DFW'(seg2_start_y_i);
      ex_q  <= DFW'(seg2_start_x_i) - DFW'(seg1_start_x_i);
      ey_q  <= DFW'(seg2_start_y_i) - DFW'(seg1_start_y_i);
      fx_q  <= DFW'(seg2_end_x_i) - DFW'(seg1_start_x_i);
      fy_q  <= DFW'(seg2_end_y_i) - DFW'(seg1_start_y_i);
      hx_q  <= DFW'(seg1_end_x_i) - DFW'(seg2_start_x_i);
      hy_q  <= DFW'(seg1_end_y_i) - DFW'(seg2_start_y_i);
      ax1_q <= seg1_start_x_i;
      ay1_q <= seg1_start_y_i;
    end
  end

  // stage 2: products
  logic                         v2_q;
  logic signed [PW-1:0]         pa_q, pb_q, pc_q, pd_q, pe_q, pf_q, pg_q, ph_q, pn_q, po_q;
  logic signed [DFW-1:0]        d1x2_q, d1y2_q;
  logic signed [COORD_BITS-1:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q   <= PW'(ex_q) * PW'(d1y_q);
      pb_q   <= PW'(ey_q) * PW'(d1x_q);
      pc_q   <= PW'(fx_q) * PW'(d1y_q);
      pd_q   <= PW'(fy_q) * PW'(d1x_q);
      pe_q   <= PW'(hx_q) * PW'(d2y_q);
      pf_q   <= PW'(hy_q) * PW'(d2x_q);
      pg_q   <= PW'(d1x_q) * PW'(d2y_q);
      ph_q   <= PW'(d1y_q) * PW'(d2x_q);
      pn_q   <= PW'(ex_q) * PW'(d2y_q);
      po_q   <= PW'(ey_q) * PW'(d2x_q);
      d1x2_q <= d1x_q;
      d1y2_q <= d1y_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
    end
  end

  // stage 3: cross products, sign test, magnitudes
  logic signed [CW-1:0] c1, c2, c4, cden, cnum;
  logic                 hit_d;

  always_comb begin
    c1   = CW'(pa_q) - CW'(pb_q);
    c2   = CW'(pc_q) - CW'(pd_q);
    c4   = CW'(pe_q) - CW'(pf_q);
    cden = CW'(pg_q) - CW'(ph_q);
    cnum = CW'(pn_q) - CW'(po_q);
    // the seg1 start side of seg2's line is the negated numerator
    hit_d = (c1 != '0) && (c2 != '0) && (c1[CW-1] != c2[CW-1])
         && (cnum != '0) && (c4 != '0) && (cnum[CW-1] == c4[CW-1])
         && (cden != '0);
  end

  logic                         v3_q, hit3_q, negx3_q, negy3_q;
  logic [CW-1:0]                num3_q, den3_q;
  logic [DFW-1:0]               mx3_q, my3_q;
  logic signed [COORD_BITS-1:0] ax3_q, ay3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit3_q  <= hit_d;
      negx3_q <= cnum[CW-1] ^ cden[CW-1] ^ d1x2_q[DFW-1];
      negy3_q <= cnum[CW-1] ^ cden[CW-1] ^ d1y2_q[DFW-1];
      num3_q  <= cnum[CW-1] ? CW'(-cnum) : CW'(cnum);
      den3_q  <= cden[CW-1] ? CW'(-cden) : CW'(cden);
      mx3_q   <= d1x2_q[DFW-1] ? DFW'(-d1x2_q) : DFW'(d1x2_q);
      my3_q   <= d1y2_q[DFW-1] ? DFW'(-d1y2_q) : DFW'(d1y2_q);
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
    end
  end

  // stage 4: scaled numerators
  logic                         v4_q, hit4_q, negx4_q, negy4_q;
  logic [NW-1:0]                nx4_q, ny4_q;
  logic [CW-1:0]                den4_q;
  logic signed [COORD_BITS-1:0] ax4_q, ay4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx4_q   <= NW'(num3_q) * NW'(mx3_q);
      ny4_q   <= NW'(num3_q) * NW'(my3_q);
      den4_q  <= den3_q;
      hit4_q  <= hit3_q;
      negx4_q <= negx3_q;
      negy4_q <= negy3_q;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
    end
  end

  // division chain, one cell per quotient bit
  logic [CW-1:0] remx [0:QW];
  logic [CW-1:0] remy [0:QW];
  logic [CW-1:0] denc [0:QW];
  logic [CW-1:0] deny [0:QW];
  logic [QW-1:0] accx [0:QW];
  logic [QW-1:0] accy [0:QW];

  // the quotient is below 2^QW, so the top part starts below the divisor
  assign remx[0] = nx4_q[NW-1:DFW];
  assign remy[0] = ny4_q[NW-1:DFW];
  assign denc[0] = den4_q;
  assign deny[0] = den4_q;
  assign accx[0] = QW'(nx4_q[DFW-1:0]) << FRAC_BITS;
  assign accy[0] = QW'(ny4_q[DFW-1:0]) << FRAC_BITS;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sipu_div_cell #(.DW(CW), .QW(QW)) u_cell_x (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (remx[i]),
      .den_i (denc[i]),
      .acc_i (accx[i]),
      .rem_o (remx[i+1]),
      .den_o (denc[i+1]),
      .acc_o (accx[i+1])
    );
    sipu_div_cell #(.DW(CW), .QW(QW)) u_cell_y (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (remy[i]),
      .den_i (deny[i]),
      .acc_i (accy[i]),
      .rem_o (remy[i+1]),
      .den_o (deny[i+1]),
      .acc_o (accy[i+1])
    );
  end

  // side data that travels alongside the cells
  logic           vld_q [0:QW-1];
  logic [SBW-1:0] sb_q  [0:QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= v4_q;
      for (int i = 1; i < QW; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= {hit4_q, negx4_q, negy4_q, ax4_q, ay4_q};
      for (int i = 1; i < QW; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // final rounding toward zero
  logic                         hit_l, negx_l, negy_l, fracx, fracy;
  logic signed [COORD_BITS-1:0] ax_l, ay_l;
  logic signed [RW-1:0]         bx, by, sx, sy;

  always_comb begin
    {hit_l, negx_l, negy_l, ax_l, ay_l} = sb_q[QW-1];
    fracx = remx[QW] != '0;
    fracy = remy[QW] != '0;
    bx = RW'(ax_l) <<< FRAC_BITS;
    by = RW'(ay_l) <<< FRAC_BITS;
    sx = negx_l ? bx - $signed(RW'(accx[QW])) - $signed(RW'(fracx))
                : bx + $signed(RW'(accx[QW]));
    sy = negy_l ? by - $signed(RW'(accy[QW])) - $signed(RW'(fracy))
                : by + $signed(RW'(accy[QW]));
    if (fracx && sx[RW-1]) begin
      sx = sx + RW'(1);
    end
    if (fracy && sy[RW-1]) begin
      sy = sy + RW'(1);
    end
  end

  // output register
  logic                     out_valid_q, hit_q;
  logic signed [PointW-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_l;
      px_q  <= hit_l ? PointW'(sx) : '0;
      py_q  <= hit_l ? PointW'(sy) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;

endmodule

// File: rtl/core/sipu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipu_checker
// Port-level checks for the segment intersection point unit.
// ----------------------------------------------------------------------------
module sipu_checker
  import sipu_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic signed [COORD_BITS-1:0] seg1_start_x_i,
  input logic signed [COORD_BITS-1:0] seg1_start_y_i,
  input logic signed [COORD_BITS-1:0] seg1_end_x_i,
  input logic signed [COORD_BITS-1:0] seg1_end_y_i,
  input logic signed [COORD_BITS-1:0] seg2_start_x_i,
  input logic signed [COORD_BITS-1:0] seg2_start_y_i,
  input logic signed [COORD_BITS-1:0] seg2_end_x_i,
  input logic signed [COORD_BITS-1:0] seg2_end_y_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         hit_o,
  input logic signed [PointW-1:0]     point_x_o,
  input logic signed [PointW-1:0]     point_y_o
);

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (point_x_o == '0 && point_y_o == '0))
    else $error("miss with nonzero point");

  // input side is only held back by a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(point_x_o) && $stable(point_y_o)))
    else $error("stalled result changed");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result withdrawn without being taken");

endmodule

bind segment_intersection_point_unit sipu_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_sipu_checker (.*);

// File: dv/segment_intersection_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_checker
// Watches both channels of the segment intersection point unit, computes the
// expected crossing result of every accepted request and compares each
// result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module segment_intersection_point_checker
  import sipu_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic signed [CoordBitsDef-1:0] seg1_start_x_i,
  input  logic signed [CoordBitsDef-1:0] seg1_start_y_i,
  input  logic signed [CoordBitsDef-1:0] seg1_end_x_i,
  input  logic signed [CoordBitsDef-1:0] seg1_end_y_i,
  input  logic signed [CoordBitsDef-1:0] seg2_start_x_i,
  input  logic signed [CoordBitsDef-1:0] seg2_start_y_i,
  input  logic signed [CoordBitsDef-1:0] seg2_end_x_i,
  input  logic signed [CoordBitsDef-1:0] seg2_end_y_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           hit_i,
  input  logic signed [PointW-1:0]       point_x_i,
  input  logic signed [PointW-1:0]       point_y_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct packed {
    logic              hit;
    logic [PointW-1:0] px;
    logic [PointW-1:0] py;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic int sgn(longint v);
    return (v == 0) ? 0 : ((v < 0) ? -1 : 1);
  endfunction

  // exact (base + num * delta / den) scaled by 2^frac, truncated toward zero
  function automatic logic [PointW-1:0] axis_point(longint base, longint delta,
                                                    longint num, longint den);
    logic signed [127:0] b, dl, n, d, q;
    b  = base;
    dl = delta;
    n  = num;
    d  = den;
    n  = (b * d + n * dl) <<< FracBitsDef;
    q  = n / d;
    return q[PointW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(longint ax, longint ay, longint bx,
                                                 longint by, longint cx, longint cy,
                                                 longint dx, longint dy);
    crossing_t r;
    longint d1x, d1y, d2x, d2y, den, num;
    int s1, s2, s3, s4;
    d1x = bx - ax;
    d1y = by - ay;
    d2x = dx - cx;
    d2y = dy - cy;
    s1  = sgn(cross2(cx - ax, cy - ay, d1x, d1y));
    s2  = sgn(cross2(dx - ax, dy - ay, d1x, d1y));
    s3  = sgn(cross2(ax - cx, ay - cy, d2x, d2y));
    s4  = sgn(cross2(bx - cx, by - cy, d2x, d2y));
    den = cross2(d1x, d1y, d2x, d2y);
    num = cross2(cx - ax, cy - ay, d2x, d2y);
    r   = '0;
    if (s1 * s2 < 0 && s3 * s4 < 0 && den != 0) begin
      r.hit = 1'b1;
      r.px  = axis_point(ax, d1x, num, den);
      r.py  = axis_point(ay, d1y, num, den);
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        crossing_q.push_back(predict_crossing(seg1_start_x_i, seg1_start_y_i,
                                              seg1_end_x_i, seg1_end_y_i,
                                              seg2_start_x_i, seg2_start_y_i,
                                              seg2_end_x_i, seg2_end_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (crossing_q.size() == 0) begin
          report("unexpected result", hit_i, 0);
        end else begin
          want = crossing_q.pop_front();
          if (hit_i !== want.hit) report("hit", hit_i, want.hit);
          if (point_x_i !== want.px) report("point_x", point_x_i, want.px);
          if (point_y_i !== want.py) report("point_y", point_y_i, want.py);
        end
      end
      pending_o <= crossing_q.size();
    end
  end

endmodule

// File: dv/segment_intersection_point_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_unit_tb
// Drives segment pairs into the intersection point unit with random gaps and
// output stalls: directed crossings, touches, collinear and degenerate cases,
// then random full-range, small-grid and built-to-cross pairs.
// ----------------------------------------------------------------------------
module segment_intersection_point_unit_tb;
  import sipu_pkg::*;

  localparam int unsigned CW = CoordBitsDef;
  localparam int StallLimit  = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid, in_ready, out_valid, out_ready, hit;
  logic signed [CW-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
  logic signed [PointW-1:0] px, py;
  int fail_count, pending;
  int idle_cycles;
  bit ready_calm;  // no output stalls while set
  bit send_calm;   // no input gaps while set
  int ready_wait;

  always #1 clk_i = ~clk_i;

  segment_intersection_point_unit u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .seg1_start_x_i(s1x), .seg1_start_y_i(s1y),
    .seg1_end_x_i(e1x), .seg1_end_y_i(e1y),
    .seg2_start_x_i(s2x), .seg2_start_y_i(s2y),
    .seg2_end_x_i(e2x), .seg2_end_y_i(e2y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_o(hit), .point_x_o(px), .point_y_o(py)
  );

  segment_intersection_point_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .seg1_start_x_i(s1x), .seg1_start_y_i(s1y),
    .seg1_end_x_i(e1x), .seg1_end_y_i(e1y),
    .seg2_start_x_i(s2x), .seg2_start_y_i(s2y),
    .seg2_end_x_i(e2x), .seg2_end_y_i(e2y),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .hit_i(hit), .point_x_i(px), .point_y_i(py),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // output side: a fresh random stall after every result
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      ready_wait = ready_calm ? 0 : $urandom_range(0, 16);
      out_ready <= (ready_wait == 0);
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_ready <= (ready_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[segment_intersection_point_unit] ERROR");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the request was taken
  task automatic send_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    s1x <= CW'(ax); s1y <= CW'(ay); e1x <= CW'(bx); e1y <= CW'(by);
    s2x <= CW'(cx); s2y <= CW'(cy); e2x <= CW'(dx); e2y <= CW'(dy);
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic int full_coord();
    return $signed(CW'($urandom_range(0, 65535)));
  endfunction

  function automatic int grid_coord();
    return $urandom_range(0, 16) - 8;
  endfunction

  task automatic send_random();
    int kind, ax, ay, bx, by, mx, my, vx, vy;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      send_pair(full_coord(), full_coord(), full_coord(), full_coord(),
                full_coord(), full_coord(), full_coord(), full_coord());
    end else if (kind < 6) begin
      send_pair(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                grid_coord(), grid_coord(), grid_coord(), grid_coord());
    end else begin
      // second segment built around a point near the middle of the first
      ax = $urandom_range(0, 32000) - 16000;
      ay = $urandom_range(0, 32000) - 16000;
      bx = $urandom_range(0, 32000) - 16000;
      by = $urandom_range(0, 32000) - 16000;
      mx = (ax + bx) / 2 + $urandom_range(0, 6) - 3;
      my = (ay + by) / 2 + $urandom_range(0, 6) - 3;
      vx = $urandom_range(0, 16000) - 8000;
      vy = $urandom_range(0, 16000) - 8000;
      send_pair(ax, ay, bx, by, mx - vx, my - vy, mx + vx, my + vy);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    out_ready = 1'b0;
    {s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y} = '0;
    idle_cycles = 0;
    ready_wait = 0;
    ready_calm = 1'b0;
    send_calm = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);             // plain x crossing
    send_pair(0, 0, 3, 7, 2, -5, -1, 9);               // fractional point
    send_pair(-7, 3, 5, -2, -6, -4, 4, 6);             // negative fractions
    send_pair(0, 0, 10, 0, 5, 0, 5, 10);               // endpoint touches line
    send_pair(0, 0, 10, 10, 10, 10, 20, 0);            // shared endpoint
    send_pair(0, 0, 10, 10, 2, 2, 20, 20);             // collinear overlap
    send_pair(0, 0, 4, 4, 6, 6, 9, 9);                 // collinear apart
    send_pair(0, 0, 10, 0, 0, 3, 10, 3);               // parallel
    send_pair(3, 3, 3, 3, 0, 0, 6, 6);                 // zero-length first
    send_pair(0, 5, 5, 0, 2, 2, 2, 2);                 // zero-length second
    send_pair(0, 0, 10, 10, 20, 0, 30, -10);           // lines cross off segments
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    send_pair(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    send_pair(0, 0, 1, 3, 1, 0, 0, 2);

    // random phases with and without idling
    for (int i = 0; i < 1450; i++) begin
      if (i % 300 == 0) begin
        send_calm  = ($urandom_range(0, 2) == 0);
        ready_calm = ($urandom_range(0, 2) == 0);
      end
      if (i == 700) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      send_random();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[segment_intersection_point_unit] OK");
    end else begin
      $display("[segment_intersection_point_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sipu_pkg.sv
rtl/core/sipu_div_cell.sv
rtl/core/segment_intersection_point_unit.sv
rtl/core/sipu_checker.sv
dv/segment_intersection_point_checker.sv
dv/segment_intersection_point_unit_tb.sv
